### rtl/core/cdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdp_pkg
// Shared types and constants for the USB configuration descriptor parser.
// ----------------------------------------------------------------------------
package cdp_pkg;

  localparam int MAX_INTERFACES_DEF = 8;

  localparam logic [7:0] DESC_CONFIG    = 8'd2;
  localparam logic [7:0] DESC_INTERFACE = 8'd4;
  localparam logic [7:0] DESC_ENDPOINT  = 8'd5;

  localparam logic [7:0] MIN_LEN    = 8'd2;
  localparam logic [7:0] IF_MIN_LEN = 8'd9;
  localparam logic [7:0] EP_MIN_LEN = 8'd7;

  localparam int PEND_DEPTH = 6;

  typedef struct packed {
    logic [7:0] num;
    logic [7:0] alt;
    logic [7:0] cls;
    logic [7:0] sub;
    logic [7:0] proto;
  } iface_id_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  addr;
    logic [15:0] mps;
    logic [7:0]  interval;
  } ep_info_t;

  typedef struct packed {
    logic      if_we;
    logic      ep_we;
    iface_id_t id;
    ep_info_t  ep;
  } tbl_wr_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } drain_t;

endpackage

### rtl/core/cdp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdp_in_if / cdp_out_if
// Valid/ready channels for blob bytes in and interface records out.
// ----------------------------------------------------------------------------
interface cdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface cdp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  interface_number;
  logic [7:0]  alternate_setting;
  logic [7:0]  interface_class;
  logic [7:0]  interface_subclass;
  logic [7:0]  interface_protocol;
  logic        endpoint_found;
  logic [7:0]  endpoint_address;
  logic [15:0] endpoint_max_packet;
  logic [7:0]  endpoint_interval;
  logic [7:0]  config_value;
  logic [3:0]  interface_count;
  logic        run_end;

  modport source (
    output valid, input ready,
    output interface_number, output alternate_setting, output interface_class,
    output interface_subclass, output interface_protocol, output endpoint_found,
    output endpoint_address, output endpoint_max_packet, output endpoint_interval,
    output config_value, output interface_count, output run_end
  );
  modport sink (
    input valid, output ready,
    input interface_number, input alternate_setting, input interface_class,
    input interface_subclass, input interface_protocol, input endpoint_found,
    input endpoint_address, input endpoint_max_packet, input endpoint_interval,
    input config_value, input interface_count, input run_end
  );
endinterface

### rtl/core/cdp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdp_parser
// Input register and per-byte descriptor walker; issues table writes.
// ----------------------------------------------------------------------------
module cdp_parser #(
  parameter int MAX_INTERFACES = cdp_pkg::MAX_INTERFACES_DEF,
  parameter int CNT_W          = $clog2(MAX_INTERFACES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  cdp_in_if.sink                bytes,
  input  logic                  drain_busy,
  input  logic                  drain_done,
  output logic                  drain_start,
  output cdp_pkg::tbl_wr_t      wr,
  output logic [CNT_W-1:0]      stored,
  output logic [7:0]            cfg
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INTERFACES);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_final;
  logic       take;

  logic [7:0] pos, pos_next;
  logic [7:0] len, len_next;
  logic [7:0] dtype, dtype_next;
  logic [7:0] pend [cdp_pkg::PEND_DEPTH];
  logic [7:0] pend_next [cdp_pkg::PEND_DEPTH];
  logic       halted, halted_next;
  logic       cur_valid, cur_valid_next;
  logic       cur_ep_found, cur_ep_found_next;
  logic [CNT_W-1:0] stored_next;
  logic [7:0] cfg_next;
  logic       commit;

  assign take        = s1_valid && !drain_busy;
  assign bytes.ready = !s1_valid || take;
  assign drain_start = take && s1_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
    if (bytes.ready) begin
      s1_byte  <= bytes.data_byte;
      s1_final <= bytes.final_byte;
    end
  end

  always_comb begin
    pos_next          = pos;
    len_next          = len;
    dtype_next        = dtype;
    pend_next         = pend;
    halted_next       = halted;
    cur_valid_next    = cur_valid;
    cur_ep_found_next = cur_ep_found;
    stored_next       = stored;
    cfg_next          = cfg;
    commit            = 1'b0;
    wr                = '0;
    wr.id.num         = pend_next[0];
    wr.id.alt         = pend_next[1];
    wr.id.cls         = pend_next[3];
    wr.id.sub         = pend_next[4];
    wr.id.proto       = pend_next[5];
    wr.ep.found       = 1'b1;
    wr.ep.addr        = pend_next[0];
    wr.ep.mps         = {pend_next[3], pend_next[2]};
    wr.ep.interval    = pend_next[4];
    if (take && !halted) begin
      if (pos == 8'd0) begin
        if (s1_byte < cdp_pkg::MIN_LEN) begin
          halted_next = 1'b1;
        end else begin
          len_next = s1_byte;
          pos_next = 8'd1;
        end
      end else begin
        if (pos == 8'd1) begin
          dtype_next = s1_byte;
        end
        for (int i = 0; i < cdp_pkg::PEND_DEPTH; i++) begin
          if (pos == 8'(i + 2)) begin
            pend_next[i] = s1_byte;
          end
        end
        commit   = ({1'b0, pos} + 9'd1) >= {1'b0, len};
        pos_next = commit ? 8'd0 : pos + 8'd1;
      end
    end
    wr.id.num      = pend_next[0];
    wr.id.alt      = pend_next[1];
    wr.id.cls      = pend_next[3];
    wr.id.sub      = pend_next[4];
    wr.id.proto    = pend_next[5];
    wr.ep.addr     = pend_next[0];
    wr.ep.mps      = {pend_next[3], pend_next[2]};
    wr.ep.interval = pend_next[4];
    if (commit) begin
      case (dtype_next)
        cdp_pkg::DESC_CONFIG: begin
          if (len >= cdp_pkg::IF_MIN_LEN) begin
            cfg_next = pend_next[3];
          end
        end
        cdp_pkg::DESC_INTERFACE: begin
          if (len >= cdp_pkg::IF_MIN_LEN && stored < MAX_CNT) begin
            wr.if_we          = 1'b1;
            stored_next       = stored + CNT_W'(1);
            cur_valid_next    = 1'b1;
            cur_ep_found_next = 1'b0;
          end else begin
            cur_valid_next = 1'b0;
          end
        end
        cdp_pkg::DESC_ENDPOINT: begin
          if (cur_valid && len >= cdp_pkg::EP_MIN_LEN && stored != '0 && !cur_ep_found &&
              pend_next[1][1:0] == 2'b11 && pend_next[0][7]) begin
            wr.ep_we          = 1'b1;
            cur_ep_found_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || drain_done) begin
      pos          <= '0;
      len          <= '0;
      dtype        <= '0;
      halted       <= 1'b0;
      cur_valid    <= 1'b0;
      cur_ep_found <= 1'b0;
      stored       <= '0;
      cfg          <= '0;
    end else begin
      pos          <= pos_next;
      len          <= len_next;
      dtype        <= dtype_next;
      halted       <= halted_next;
      cur_valid    <= cur_valid_next;
      cur_ep_found <= cur_ep_found_next;
      stored       <= stored_next;
      cfg          <= cfg_next;
    end
    pend <= pend_next;
  end

endmodule

### rtl/core/cdp_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdp_table
// Interface and endpoint tables, drain sequencer and result register.
// ----------------------------------------------------------------------------
module cdp_table #(
  parameter int MAX_INTERFACES = cdp_pkg::MAX_INTERFACES_DEF,
  parameter int CNT_W          = $clog2(MAX_INTERFACES + 1),
  parameter int IDX_W          = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cdp_pkg::tbl_wr_t      wr,
  input  logic [CNT_W-1:0]      stored,
  input  logic [7:0]            cfg,
  input  logic                  drain_start,
  output cdp_pkg::drain_t       drain,
  cdp_out_if.source             results
);

  cdp_pkg::iface_id_t id_tbl [MAX_INTERFACES];
  cdp_pkg::ep_info_t  ep_tbl [MAX_INTERFACES];

  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] ep_idx;
  logic             busy;
  logic             load;
  logic             empty;
  logic             last;
  cdp_pkg::iface_id_t rd_id;
  cdp_pkg::ep_info_t  rd_ep;

  assign ep_idx = stored - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (wr.if_we) begin
      id_tbl[stored[IDX_W-1:0]] <= wr.id;
      ep_tbl[stored[IDX_W-1:0]] <= '0;
    end else if (wr.ep_we) begin
      ep_tbl[ep_idx[IDX_W-1:0]] <= wr.ep;
    end
  end

  assign empty = (stored == '0);
  assign last  = empty || (idx + CNT_W'(1) == stored);
  assign load  = busy && (!results.valid || results.ready);
  assign rd_id = empty ? '0 : id_tbl[idx[IDX_W-1:0]];
  assign rd_ep = empty ? '0 : ep_tbl[idx[IDX_W-1:0]];

  assign drain.start = drain_start;
  assign drain.busy  = busy;
  assign drain.done  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      idx           <= '0;
      results.valid <= 1'b0;
    end else begin
      if (drain_start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (load) begin
        if (last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + CNT_W'(1);
        end
      end
      if (load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
    if (load) begin
      results.interface_number    <= rd_id.num;
      results.alternate_setting   <= rd_id.alt;
      results.interface_class     <= rd_id.cls;
      results.interface_subclass  <= rd_id.sub;
      results.interface_protocol  <= rd_id.proto;
      results.endpoint_found      <= rd_ep.found;
      results.endpoint_address    <= rd_ep.addr;
      results.endpoint_max_packet <= rd_ep.mps;
      results.endpoint_interval   <= rd_ep.interval;
      results.config_value        <= cfg;
      results.interface_count     <= 4'(stored);
      results.run_end             <= last;
    end
  end

endmodule

### rtl/core/usb_config_descriptor_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_config_descriptor_parser_top
// Each byte is registered in the input register and parsed from there; taking
//   a blob's final byte starts the drain, whose results are registered at the output.
// Throughput: one byte per cycle while no drain runs; a blob end emits max(1,
//   stored interfaces) results, one per cycle unless the output stalls, and the
//   next byte waits in the input register until the last result is loaded.
// Reset: synchronous; clears parser state, drain sequencer and output valid.
// ----------------------------------------------------------------------------
module usb_config_descriptor_parser_top #(
  parameter int MAX_INTERFACES = cdp_pkg::MAX_INTERFACES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cdp_in_if.sink     bytes,
  cdp_out_if.source  results
);

  localparam int CNT_W = $clog2(MAX_INTERFACES + 1);

  cdp_pkg::tbl_wr_t wr;
  cdp_pkg::drain_t  drain;
  logic [CNT_W-1:0] stored;
  logic [7:0]       cfg;
  logic             drain_start;

  cdp_parser #(
    .MAX_INTERFACES (MAX_INTERFACES),
    .CNT_W          (CNT_W)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .bytes       (bytes),
    .drain_busy  (drain.busy),
    .drain_done  (drain.done),
    .drain_start (drain_start),
    .wr          (wr),
    .stored      (stored),
    .cfg         (cfg)
  );

  cdp_table #(
    .MAX_INTERFACES (MAX_INTERFACES),
    .CNT_W          (CNT_W)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .stored      (stored),
    .cfg         (cfg),
    .drain_start (drain_start),
    .drain       (drain),
    .results     (results)
  );

endmodule
